// ===== sv/nmcf_pkg.sv =====
// Shared widths and codes for the network-management channel state machine.
package nmcf_pkg;

  localparam int MODE_W     = 3;
  localparam int CHAN_W     = 8;
  localparam int CSTATE_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int ACTIVE_W   = 4;
  localparam int RELOAD_W   = 16;

  localparam logic [CSTATE_W-1:0] ST_BUS_SLEEP   = 3'd0;
  localparam logic [CSTATE_W-1:0] ST_PREP_SLEEP  = 3'd1;
  localparam logic [CSTATE_W-1:0] ST_READY_SLEEP = 3'd2;
  localparam logic [CSTATE_W-1:0] ST_NORMAL      = 3'd3;
  localparam logic [CSTATE_W-1:0] ST_REPEAT      = 3'd4;

  localparam logic [MODE_W-1:0] EV_REQUEST = 3'd0;
  localparam logic [MODE_W-1:0] EV_RELEASE = 3'd1;
  localparam logic [MODE_W-1:0] EV_QUERY   = 3'd2;
  localparam logic [MODE_W-1:0] EV_START   = 3'd3;
  localparam logic [MODE_W-1:0] EV_TICK    = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT  = 2'd2;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RST  = 4'd1;
  localparam logic [RELOAD_W-1:0] TIMEOUT_RST = 16'd100;
  localparam logic [RELOAD_W-1:0] REPEAT_RST  = 16'd10;

endpackage

// ===== sv/nmcf_if.sv =====
// Valid/ready channel interfaces: event requests, results and register writes.
interface nmcf_req_if;
  logic                        valid;
  logic                        ready;
  logic [nmcf_pkg::MODE_W-1:0] mode;
  logic [nmcf_pkg::CHAN_W-1:0] channel;
  modport source (output valid, mode, channel, input ready);
  modport sink (input valid, mode, channel, output ready);
endinterface

interface nmcf_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          status;
  logic [nmcf_pkg::CSTATE_W-1:0] chan_state;
  logic                          net_mode;
  modport source (output valid, status, chan_state, net_mode, input ready);
  modport sink (input valid, status, chan_state, net_mode, output ready);
endinterface

interface nmcf_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [nmcf_pkg::CFG_IDX_W-1:0]  index;
  logic [nmcf_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/network_mgmt_channel_fsm.sv =====
// Network-management channel state machine: per-channel state held in one RAM.
//
//   channel  | dir | payload              | transfer when
//   req_ch   | in  | mode, channel        | valid && ready
//   rsp_ch   | out | status, chan_state,  | valid && ready
//            |     | net_mode             |
//   cfg_ch   | in  | index, data          | valid && ready (ready tied high)
//
// Events pass from transfer through the event state to the result register; an
// invalid channel skips it. A tick sweeps the active channels: the sweep reads
// one entry and writes back the previous one each cycle via the single channel RAM.
// req_ch is ready again the cycle after the result register loads.
// Reset: synchronous; entries read as bus sleep until first written.
// A stalled result holds the engine in its result state; req_ch waits until idle.
module network_mgmt_channel_fsm #(
  parameter int MAX_CHANNELS = 8,
  parameter int TIMER_BITS   = 16
) (
  input logic      clk,
  input logic      rst,
  nmcf_req_if.sink   req_ch,
  nmcf_rsp_if.source rsp_ch,
  nmcf_cfg_if.sink   cfg_ch
);

  localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNT_W = $clog2(MAX_CHANNELS + 1);

  typedef struct packed {
    logic [nmcf_pkg::CSTATE_W-1:0] st;
    logic                          flag;
    logic [TIMER_BITS-1:0]         tmr;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_EVENT  = 4'b0010,
    S_SWEEP  = 4'b0100,
    S_RESULT = 4'b1000
  } fsm_t;

  fsm_t state, state_next;

  logic [nmcf_pkg::ACTIVE_W-1:0] active_channels;
  logic [nmcf_pkg::RELOAD_W-1:0] timeout_ticks;
  logic [nmcf_pkg::RELOAD_W-1:0] repeat_ticks;

  entry_t                mem [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0] vld;
  entry_t                rd_data;
  logic                  rd_vld;
  logic [CH_W-1:0]       rd_addr;
  logic                  mem_we;
  logic [CH_W-1:0]       mem_waddr;
  entry_t                mem_wdata;

  logic [nmcf_pkg::MODE_W-1:0]   cur_mode;
  logic [CH_W-1:0]               cur_idx;
  logic                          cur_ok;
  logic [CH_W-1:0]               idx;
  logic                          res_status;
  logic [nmcf_pkg::CSTATE_W-1:0] res_state;

  logic                          out_valid;
  logic                          out_status;
  logic [nmcf_pkg::CSTATE_W-1:0] out_state;

  logic [CNT_W-1:0]      live;
  logic                  req_ok;
  logic                  req_xfer;
  logic                  out_free;
  logic                  last;
  logic [TIMER_BITS-1:0] reload;
  logic [TIMER_BITS-1:0] rpt_reload;
  logic [TIMER_BITS-1:0] t1;
  entry_t                rd_entry;
  entry_t                tick_entry;
  entry_t                ev_entry;

  assign live = (active_channels < MAX_CHANNELS) ? CNT_W'(active_channels)
                                                 : CNT_W'(MAX_CHANNELS);
  assign req_ok     = ({1'b0, req_ch.channel} < (nmcf_pkg::CHAN_W + 1)'(live));
  assign req_xfer   = req_ch.valid && req_ch.ready;
  assign out_free   = !out_valid || rsp_ch.ready;
  assign last       = (CNT_W'(idx) + CNT_W'(1)) == live;
  assign reload     = TIMER_BITS'(timeout_ticks);
  assign rpt_reload = TIMER_BITS'(repeat_ticks);

  assign req_ch.ready      = (state == S_IDLE);
  assign cfg_ch.ready      = 1'b1;
  assign rsp_ch.valid      = out_valid;
  assign rsp_ch.status     = out_status;
  assign rsp_ch.chan_state = out_state;
  assign rsp_ch.net_mode   = (out_state != nmcf_pkg::ST_BUS_SLEEP);

  always_ff @(posedge clk) begin
    if (rst) begin
      active_channels <= nmcf_pkg::ACTIVE_RST;
      timeout_ticks   <= nmcf_pkg::TIMEOUT_RST;
      repeat_ticks    <= nmcf_pkg::REPEAT_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        nmcf_pkg::CFG_ACTIVE:  active_channels <= cfg_ch.data[nmcf_pkg::ACTIVE_W-1:0];
        nmcf_pkg::CFG_TIMEOUT: timeout_ticks <= cfg_ch.data;
        nmcf_pkg::CFG_REPEAT:  repeat_ticks <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // channel RAM, registered read
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= vld[rd_addr];
      if (mem_we) begin
        vld[mem_waddr] <= 1'b1;
      end
    end
  end

  assign rd_entry = rd_vld ? rd_data : '0;

  always_comb begin
    unique case (state)
      S_IDLE:  rd_addr = (req_ch.mode == nmcf_pkg::EV_TICK) ? '0
                                                            : req_ch.channel[CH_W-1:0];
      S_SWEEP: rd_addr = idx + CH_W'(1);
      default: rd_addr = idx;
    endcase
  end

  always_comb begin
    t1         = rd_entry.tmr - TIMER_BITS'(rd_entry.tmr != '0);
    tick_entry = rd_entry;
    tick_entry.tmr = t1;
    case (rd_entry.st)
      nmcf_pkg::ST_REPEAT: begin
        if (t1 == '0) begin
          tick_entry.st  = nmcf_pkg::ST_NORMAL;
          tick_entry.tmr = reload;
        end
      end
      nmcf_pkg::ST_NORMAL: begin
        if (!rd_entry.flag) begin
          tick_entry.st  = nmcf_pkg::ST_READY_SLEEP;
          tick_entry.tmr = reload;
        end else if (t1 == '0) begin
          tick_entry.tmr = reload;
        end
      end
      nmcf_pkg::ST_READY_SLEEP: begin
        if (rd_entry.flag) begin
          tick_entry.st  = nmcf_pkg::ST_NORMAL;
          tick_entry.tmr = reload;
        end else if (t1 == '0) begin
          tick_entry.st  = nmcf_pkg::ST_PREP_SLEEP;
          tick_entry.tmr = reload;
        end
      end
      nmcf_pkg::ST_PREP_SLEEP: begin
        if (rd_entry.flag) begin
          tick_entry.st  = nmcf_pkg::ST_REPEAT;
          tick_entry.tmr = rpt_reload;
        end else if (t1 == '0) begin
          tick_entry.st = nmcf_pkg::ST_BUS_SLEEP;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    ev_entry = rd_entry;
    case (cur_mode)
      nmcf_pkg::EV_REQUEST: begin
        ev_entry.flag = 1'b1;
        if (rd_entry.st == nmcf_pkg::ST_BUS_SLEEP || rd_entry.st == nmcf_pkg::ST_PREP_SLEEP) begin
          ev_entry.st  = nmcf_pkg::ST_REPEAT;
          ev_entry.tmr = rpt_reload;
        end
      end
      nmcf_pkg::EV_RELEASE: ev_entry.flag = 1'b0;
      nmcf_pkg::EV_START: begin
        if (rd_entry.st == nmcf_pkg::ST_BUS_SLEEP) begin
          ev_entry.st  = nmcf_pkg::ST_REPEAT;
          ev_entry.tmr = rpt_reload;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = tick_entry;
    unique case (state)
      S_EVENT: begin
        mem_we    = 1'b1;
        mem_waddr = cur_idx;
        mem_wdata = ev_entry;
      end
      S_SWEEP: mem_we = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_xfer) begin
          if (req_ch.mode == nmcf_pkg::EV_TICK) begin
            state_next = (live != '0) ? S_SWEEP : S_RESULT;
          end else begin
            state_next = req_ok ? S_EVENT : S_RESULT;
          end
        end
      end
      S_EVENT: state_next = S_RESULT;
      S_SWEEP: begin
        if (last) begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (req_xfer) begin
          cur_mode   <= req_ch.mode;
          cur_idx    <= req_ch.channel[CH_W-1:0];
          cur_ok     <= req_ok;
          idx        <= '0;
          res_status <= !req_ok && (req_ch.mode != nmcf_pkg::EV_TICK);
          res_state  <= nmcf_pkg::ST_BUS_SLEEP;
        end
      end
      S_EVENT: res_state <= ev_entry.st;
      S_SWEEP: begin
        if (cur_ok && idx == cur_idx) begin
          res_state <= tick_entry.st;
        end
        idx <= idx + CH_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (state == S_RESULT && out_free) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESULT && out_free) begin
      out_status <= res_status;
      out_state  <= res_state;
    end
  end

  a_sweep_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SWEEP |-> CNT_W'(idx) < live)
    else $error("sweep index beyond active channels");

  a_ram_write_phase: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_EVENT || state == S_SWEEP))
    else $error("channel RAM written outside event or sweep");

  a_not_ok_result: assert property (@(posedge clk) disable iff (rst)
    rsp_ch.valid && rsp_ch.status |-> rsp_ch.chan_state == nmcf_pkg::ST_BUS_SLEEP)
    else $error("not-ok result carries a channel state");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    state == S_RESULT && out_free |=> rsp_ch.valid && state == S_IDLE)
    else $error("result not loaded into output register");

endmodule
